// ----- rtl/sas_pkg.sv -----
// Shared types and constants of the sprite animation sequencer.
package sas_pkg;

    // Table geometry
    localparam int STATE_W   = 4;
    localparam int TRIG_W    = 4;
    localparam int FRAME_AW  = 8;
    localparam int NUM_STATES   = 1 << STATE_W;
    localparam int NUM_TRIGGERS = 1 << TRIG_W;
    localparam int FRAME_DEPTH  = 1 << FRAME_AW;
    localparam int XFER_DEPTH   = NUM_STATES * NUM_TRIGGERS;

    localparam int CMD_W  = 3;
    localparam int CNT_W  = 9;
    localparam int POS_W  = 8;
    localparam int TIME_W = 16;
    localparam int SPR_W  = 16;

    // Largest frame count a descriptor holds
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(256);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TRIGGER  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WR_FRAME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WR_DESC  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WR_XFER  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd6;

    // Configuration register indexes
    localparam logic CFG_DEFAULT_STATE = 1'b0;
    localparam logic CFG_EMPTY_SPRITE  = 1'b1;

    // State descriptor, validity held apart in flops
    typedef struct packed {
        logic              loop;
        logic [POS_W-1:0]  base;
        logic [CNT_W-1:0]  count;
    } desc_t;

    // Per-state runtime; stored time never goes negative
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [TIME_W-1:0] tleft;
    } run_t;

    // Frame table entry
    typedef struct packed {
        logic [SPR_W-1:0]  sprite;
        logic [TIME_W-1:0] dur;
    } frame_t;

    // Outcome of one tick on the active state
    typedef struct packed {
        logic                expire;
        logic [POS_W-1:0]    pos;
        logic [TIME_W-1:0]   tleft;
        logic [FRAME_AW-1:0] faddr;
    } tick_res_t;

endpackage

// ----- rtl/sas_tick.sv -----
// Tick arithmetic: time countdown, frame advance and next frame address.
module sas_tick
    import sas_pkg::*;
(
    input  desc_t             desc,
    input  run_t              run,
    input  logic [TIME_W-1:0] dt,
    output tick_res_t         res
);

    logic signed [TIME_W:0] diff;
    logic [CNT_W-1:0]       pos_inc;
    logic [POS_W-1:0]       npos;

    // Remaining time after this tick, signed
    assign diff = signed'({1'b0, run.tleft}) - signed'({1'b0, dt});

    // Advance: wrap to the first frame only when looping, else hold the last
    assign pos_inc = {1'b0, run.pos} + CNT_W'(1);

    always_comb begin
        if (pos_inc == desc.count) begin
            npos = desc.loop ? '0 : run.pos;
        end else begin
            npos = pos_inc[POS_W-1:0];
        end
    end

    assign res.expire = diff[TIME_W] || (diff == '0);
    assign res.pos    = res.expire ? npos : run.pos;
    assign res.tleft  = diff[TIME_W-1:0];
    assign res.faddr  = desc.base + npos;

endmodule

// ----- rtl/sprite_animation_sequencer.sv -----
// Sprite animation sequencer top level: command sequencer over the state memories.
//
// Input channel s_*: one command word per handshake (tick, trigger, set state,
// table writes, start). Result channel m_*: exactly one result word per command,
// showing the display after that command (sprite, presence, active state,
// frame position and remaining time).
// Configuration: cfg_we / cfg_index / cfg_wdata write default_state (index 0)
// and empty_sprite (index 1); write only while no command is in flight.
//
// From accept to m_valid a command passes the execute, report, frame and
// output steps; a tick that ends a frame adds a reload step (duration reload
// from the frame table) and a trigger or set state that selects a state adds
// a zero step (read-modify-write of its runtime entry). A new command is taken
// only in the idle step, once the last one has left the output step. The steps
// follow from the runtime memory read-modify-write and the dependent descriptor,
// runtime and frame table reads for the result, all memories with registered reads.
//
// Reset clears the descriptor, transfer and runtime valid bits;
// no clearing pass is needed. The frame table is undefined until written.
// A stalled receiver holds the result in the output register; one more
// command is still taken and worked through, then waits in the last step
// until the held word leaves, and no further command is taken meanwhile.
module sprite_animation_sequencer
    import sas_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [SPR_W-1:0]         cfg_wdata,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic [TIME_W-1:0]        s_dt,
    input  logic [TRIG_W-1:0]        s_trigger_id,
    input  logic [STATE_W-1:0]       s_state_id,
    input  logic [FRAME_AW-1:0]      s_frame_addr,
    input  logic [SPR_W-1:0]         s_sprite_id,
    input  logic [TIME_W-1:0]        s_duration,
    input  logic [POS_W-1:0]         s_frame_base,
    input  logic [CNT_W-1:0]         s_frame_count,
    input  logic                     s_loop_flag,
    input  logic [STATE_W-1:0]       s_next_state,
    input  logic                     s_entry_valid,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SPR_W-1:0]         m_out_sprite,
    output logic                     m_sprite_present,
    output logic                     m_state_active,
    output logic [STATE_W-1:0]       m_active_state_out,
    output logic [POS_W-1:0]         m_frame_pos_out,
    output logic signed [TIME_W:0]   m_time_left_out
);

    // Sequencer steps
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_RELOAD = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;
    localparam logic [2:0] ST_FRAME  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam int XFER_AW = STATE_W + TRIG_W;

    logic [2:0]          st_reg, st_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic [STATE_W-1:0]  sid_reg;
    logic                act_reg, act_next;
    logic [STATE_W-1:0]  ai_reg, ai_next;
    logic [STATE_W-1:0]  tgt_reg, tgt_next;
    logic [POS_W-1:0]    npos_reg, npos_next;
    logic [STATE_W-1:0]  def_state_reg;
    logic [SPR_W-1:0]    empty_reg;

    logic [NUM_STATES-1:0] desc_valid_reg;
    logic [NUM_STATES-1:0] run_valid_reg;
    logic [XFER_DEPTH-1:0] xfer_valid_reg;

    // Memories
    desc_t               desc_mem  [NUM_STATES];
    run_t                run_mem   [NUM_STATES];
    frame_t              frame_mem [FRAME_DEPTH];
    logic [STATE_W-1:0]  xfer_mem  [XFER_DEPTH];

    desc_t               desc_rd;
    run_t                run_rd;
    logic                run_ok_rd;
    frame_t              frame_rd;
    logic [STATE_W-1:0]  xfer_rd;
    logic                xfer_ok_rd;

    // Latched report fields
    logic                pres_reg, pres_next;
    logic [POS_W-1:0]    pos_lat_reg;
    logic [TIME_W-1:0]   tleft_lat_reg;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [SPR_W-1:0]    m_sprite_reg;
    logic                m_present_reg;
    logic                m_active_reg;
    logic [STATE_W-1:0]  m_state_reg;
    logic [POS_W-1:0]    m_pos_reg;
    logic [TIME_W-1:0]   m_tleft_reg;

    logic                accept;
    logic                out_load;
    run_t                run_eff;
    tick_res_t           tick_res;
    logic                frame_here;

    logic                run_we;
    logic [STATE_W-1:0]  run_waddr;
    run_t                run_wdata;
    logic [STATE_W-1:0]  run_raddr;
    logic                frame_re;
    logic [FRAME_AW-1:0] frame_raddr;
    logic [CNT_W-1:0]    cnt_sat;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (st_reg == ST_IDLE);
    assign out_load = (st_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Never-written runtime entries read as position and time zero
    assign run_eff  = run_ok_rd ? run_rd : '0;

    assign frame_here = act_reg && desc_valid_reg[ai_reg] &&
                        ({1'b0, run_eff.pos} < desc_rd.count);

    sas_tick u_tick (
        .desc (desc_rd),
        .run  (run_eff),
        .dt   (dt_reg),
        .res  (tick_res)
    );

    // Frame count saturates at 256
    assign cnt_sat = (s_frame_count > CNT_MAX) ? CNT_MAX : s_frame_count;

    // Memory addressing
    assign run_raddr   = (st_reg == ST_EXEC) ? tgt_next : ai_reg;
    assign frame_re    = (st_reg == ST_EXEC) || (st_reg == ST_FRAME);
    assign frame_raddr = (st_reg == ST_EXEC) ? tick_res.faddr
                                             : FRAME_AW'(desc_rd.base + run_eff.pos);

    // Sequencer and runtime write control
    always_comb begin
        st_next   = st_reg;
        act_next  = act_reg;
        ai_next   = ai_reg;
        tgt_next  = tgt_reg;
        npos_next = npos_reg;
        pres_next = pres_reg;
        run_we    = 1'b0;
        run_waddr = ai_reg;
        run_wdata = run_eff;

        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                st_next = ST_REPORT;
                unique case (cmd_reg)
                    CMD_TICK: begin
                        if (frame_here) begin
                            if (tick_res.expire) begin
                                npos_next = tick_res.pos;
                                st_next   = ST_RELOAD;
                            end else begin
                                run_we    = 1'b1;
                                run_wdata = '{pos: run_eff.pos, tleft: tick_res.tleft};
                            end
                        end
                    end
                    CMD_TRIGGER: begin
                        tgt_next = xfer_rd;
                        if (act_reg && xfer_ok_rd && desc_valid_reg[xfer_rd]) begin
                            st_next = ST_ZERO;
                        end
                    end
                    CMD_SET: begin
                        tgt_next = sid_reg;
                        if (desc_valid_reg[sid_reg] && !(act_reg && ai_reg == sid_reg)) begin
                            st_next = ST_ZERO;
                        end
                    end
                    CMD_START: begin
                        if (desc_valid_reg[def_state_reg]) begin
                            act_next = 1'b1;
                            ai_next  = def_state_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ZERO: begin
                // Select target, zero its position, keep its time
                run_we    = 1'b1;
                run_waddr = tgt_reg;
                run_wdata = '{pos: '0, tleft: run_eff.tleft};
                act_next  = 1'b1;
                ai_next   = tgt_reg;
                st_next   = ST_REPORT;
            end
            ST_RELOAD: begin
                run_we    = 1'b1;
                run_wdata = '{pos: npos_reg, tleft: frame_rd.dur};
                st_next   = ST_REPORT;
            end
            ST_REPORT: begin
                st_next = ST_FRAME;
            end
            ST_FRAME: begin
                pres_next = frame_here;
                st_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            act_reg        <= 1'b0;
            ai_reg         <= '0;
            def_state_reg  <= '0;
            empty_reg      <= '0;
            desc_valid_reg <= '0;
            run_valid_reg  <= '0;
            xfer_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg      <= st_next;
            act_reg     <= act_next;
            ai_reg      <= ai_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                if (cfg_index == CFG_DEFAULT_STATE) begin
                    def_state_reg <= cfg_wdata[STATE_W-1:0];
                end else begin
                    empty_reg <= cfg_wdata;
                end
            end
            if (accept && s_command == CMD_WR_DESC) begin
                desc_valid_reg[s_state_id] <= s_entry_valid;
            end
            if (accept && s_command == CMD_WR_XFER) begin
                xfer_valid_reg[{s_state_id, s_trigger_id}] <= s_entry_valid;
            end
            if (run_we) begin
                run_valid_reg[run_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_command;
            dt_reg  <= s_dt;
            sid_reg <= s_state_id;
        end
        tgt_reg  <= tgt_next;
        npos_reg <= npos_next;
        pres_reg <= pres_next;
        if (st_reg == ST_FRAME) begin
            pos_lat_reg   <= act_reg ? run_eff.pos : '0;
            tleft_lat_reg <= act_reg ? run_eff.tleft : '0;
        end
        if (out_load) begin
            m_sprite_reg  <= pres_reg ? frame_rd.sprite : empty_reg;
            m_present_reg <= pres_reg;
            m_active_reg  <= act_reg;
            m_state_reg   <= ai_reg;
            m_pos_reg     <= pos_lat_reg;
            m_tleft_reg   <= tleft_lat_reg;
        end
    end

    // Descriptor memory
    always_ff @(posedge aclk) begin
        if (accept && s_command == CMD_WR_DESC) begin
            desc_mem[s_state_id] <= '{loop: s_loop_flag, base: s_frame_base, count: cnt_sat};
        end
        desc_rd <= desc_mem[ai_reg];
    end

    // Runtime memory
    always_ff @(posedge aclk) begin
        if (run_we) begin
            run_mem[run_waddr] <= run_wdata;
        end
        run_rd    <= run_mem[run_raddr];
        run_ok_rd <= run_valid_reg[run_raddr];
    end

    // Frame table
    always_ff @(posedge aclk) begin
        if (accept && s_command == CMD_WR_FRAME) begin
            frame_mem[s_frame_addr] <= '{sprite: s_sprite_id, dur: s_duration};
        end
        if (frame_re) begin
            frame_rd <= frame_mem[frame_raddr];
        end
    end

    // Transfer table, indexed by active state and trigger
    always_ff @(posedge aclk) begin
        if (accept && s_command == CMD_WR_XFER) begin
            xfer_mem[{s_state_id, s_trigger_id}] <= s_next_state;
        end
        if (st_reg == ST_IDLE) begin
            xfer_rd    <= xfer_mem[XFER_AW'({ai_reg, s_trigger_id})];
            xfer_ok_rd <= xfer_valid_reg[XFER_AW'({ai_reg, s_trigger_id})];
        end
    end

    // Result ports
    assign m_valid            = m_valid_reg;
    assign m_out_sprite       = m_sprite_reg;
    assign m_sprite_present   = m_present_reg;
    assign m_state_active     = m_active_reg;
    assign m_active_state_out = m_state_reg;
    assign m_frame_pos_out    = m_pos_reg;
    assign m_time_left_out    = signed'({1'b0, m_tleft_reg});

    // A visible sprite needs a selected state
    a_present_needs_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_sprite_present || m_state_active))
        else $error("sprite present without an active state");

    // An accepted word always goes to the execute step next
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (st_reg == ST_EXEC))
        else $error("accepted word not executed");

    // A new result only comes from the final step
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(st_reg) == ST_OUT))
        else $error("result loaded outside the output step");

    // Runtime writes while executing a tick only touch an active state
    a_tick_write_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_we && st_reg == ST_EXEC) |-> (act_reg && cmd_reg == CMD_TICK))
        else $error("runtime write without an active state");

endmodule

// ----- tb/sprite_display_checker.sv -----
// Checker for the sprite animation sequencer: predicts each result word and compares it.
`timescale 1ns / 100ps

module sprite_display_checker
    import sas_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [SPR_W-1:0]       cfg_wdata,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [TIME_W-1:0]      s_dt,
    input  logic [TRIG_W-1:0]      s_trigger_id,
    input  logic [STATE_W-1:0]     s_state_id,
    input  logic [FRAME_AW-1:0]    s_frame_addr,
    input  logic [SPR_W-1:0]       s_sprite_id,
    input  logic [TIME_W-1:0]      s_duration,
    input  logic [POS_W-1:0]       s_frame_base,
    input  logic [CNT_W-1:0]       s_frame_count,
    input  logic                   s_loop_flag,
    input  logic [STATE_W-1:0]     s_next_state,
    input  logic                   s_entry_valid,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [SPR_W-1:0]       m_out_sprite,
    input  logic                   m_sprite_present,
    input  logic                   m_state_active,
    input  logic [STATE_W-1:0]     m_active_state_out,
    input  logic [POS_W-1:0]       m_frame_pos_out,
    input  logic signed [TIME_W:0] m_time_left_out,

    output int                     n_open,
    output int                     n_fail
);

    // One displayed result word
    typedef struct packed {
        logic [SPR_W-1:0]   sprite;
        logic               present;
        logic               active;
        logic [STATE_W-1:0] state;
        logic [POS_W-1:0]   pos;
        logic [TIME_W:0]    tleft;
    } shown_t;

    // Shadow copy of the block's tables and selection
    logic               desc_ok   [NUM_STATES];
    desc_t              desc_tab  [NUM_STATES];
    frame_t             frame_tab [FRAME_DEPTH];
    logic               xfer_ok   [XFER_DEPTH];
    logic [STATE_W-1:0] xfer_dest [XFER_DEPTH];
    int                 run_pos   [NUM_STATES];
    int                 run_time  [NUM_STATES];
    logic               shown_on;
    logic [STATE_W-1:0] cur_state;
    logic [STATE_W-1:0] dflt_state;
    logic [SPR_W-1:0]   blank_sprite;

    shown_t shown_q[$];
    int     errors = 0;

    // Active state has a valid descriptor and its position lies inside it
    function automatic logic frame_ready();
        return shown_on && desc_ok[cur_state] &&
               run_pos[cur_state] < int'(desc_tab[cur_state].count);
    endfunction

    function automatic logic [FRAME_AW-1:0] frame_slot(input logic [STATE_W-1:0] s);
        return FRAME_AW'(int'(desc_tab[s].base) + run_pos[s]);
    endfunction

    function automatic void enter_state(input logic [STATE_W-1:0] s);
        shown_on     = 1'b1;
        cur_state    = s;
        run_pos[s]   = 0;
    endfunction

    // Apply the accepted command word and return the display that follows
    function automatic shown_t animate();
        shown_t             r;
        int                 cnt;
        int                 idx;
        logic [STATE_W-1:0] s;
        case (s_command)
            CMD_TICK: begin
                if (frame_ready()) begin
                    s = cur_state;
                    cnt = int'(desc_tab[s].count);
                    run_time[s] -= int'(s_dt);
                    if (run_time[s] <= 0) begin
                        // hold on the last frame unless looping
                        if (run_pos[s] != cnt - 1 || desc_tab[s].loop)
                            run_pos[s] = (run_pos[s] + 1) % cnt;
                        run_time[s] = int'(frame_tab[frame_slot(s)].dur);
                    end
                end
            end
            CMD_TRIGGER: begin
                idx = int'(cur_state) * NUM_TRIGGERS + int'(s_trigger_id);
                if (shown_on && xfer_ok[idx] && desc_ok[xfer_dest[idx]])
                    enter_state(xfer_dest[idx]);
            end
            CMD_SET: begin
                if (desc_ok[s_state_id] && !(shown_on && cur_state == s_state_id))
                    enter_state(s_state_id);
            end
            CMD_WR_FRAME: begin
                frame_tab[s_frame_addr] = '{sprite: s_sprite_id, dur: s_duration};
            end
            CMD_WR_DESC: begin
                desc_ok[s_state_id]  = s_entry_valid;
                desc_tab[s_state_id] = '{loop: s_loop_flag, base: s_frame_base,
                    count: (s_frame_count > CNT_MAX) ? CNT_MAX : s_frame_count};
            end
            CMD_WR_XFER: begin
                idx = int'(s_state_id) * NUM_TRIGGERS + int'(s_trigger_id);
                xfer_ok[idx]   = s_entry_valid;
                xfer_dest[idx] = s_next_state;
            end
            CMD_START: begin
                // position and time of the default state are kept
                if (desc_ok[dflt_state]) begin
                    shown_on  = 1'b1;
                    cur_state = dflt_state;
                end
            end
            default: ;
        endcase
        r.present = frame_ready();
        r.sprite  = r.present ? frame_tab[frame_slot(cur_state)].sprite : blank_sprite;
        r.active  = shown_on;
        r.state   = cur_state;
        r.pos     = shown_on ? POS_W'(run_pos[cur_state]) : '0;
        r.tleft   = shown_on ? (TIME_W+1)'(run_time[cur_state]) : '0;
        return r;
    endfunction

    function automatic void note_field(input string field, input logic [31:0] want,
                                       input logic [31:0] seen);
        if (want !== seen) begin
            errors++;
            if (errors <= 10)
                $display("%t: %s mismatch, expected %0h, got %0h", $realtime, field, want, seen);
        end
    endfunction

    // Predict on every accepted command word, compare on every result word
    always @(posedge aclk) begin
        shown_t exp_w;
        shown_t got_w;
        shown_t pred_w;
        if (!aresetn) begin
            for (int i = 0; i < NUM_STATES; i++) begin
                desc_ok[i]  = 1'b0;
                desc_tab[i] = '0;
                run_pos[i]  = 0;
                run_time[i] = 0;
            end
            for (int i = 0; i < XFER_DEPTH; i++) begin
                xfer_ok[i]   = 1'b0;
                xfer_dest[i] = '0;
            end
            for (int i = 0; i < FRAME_DEPTH; i++)
                frame_tab[i] = '0;
            shown_on     = 1'b0;
            cur_state    = '0;
            dflt_state   = '0;
            blank_sprite = '0;
            shown_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DEFAULT_STATE: dflt_state   = cfg_wdata[STATE_W-1:0];
                    CFG_EMPTY_SPRITE:  blank_sprite = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pred_w  = animate();
                shown_q = {shown_q, pred_w};
            end
            if (m_valid && m_ready) begin
                got_w = '{sprite: m_out_sprite, present: m_sprite_present,
                          active: m_state_active, state: m_active_state_out,
                          pos: m_frame_pos_out, tleft: m_time_left_out};
                if (shown_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: result word with none expected", $realtime);
                end else begin
                    exp_w = shown_q.pop_front();
                    note_field("out_sprite", 32'(exp_w.sprite), 32'(got_w.sprite));
                    note_field("sprite_present", 32'(exp_w.present), 32'(got_w.present));
                    note_field("state_active", 32'(exp_w.active), 32'(got_w.active));
                    note_field("active_state_out", 32'(exp_w.state), 32'(got_w.state));
                    note_field("frame_pos_out", 32'(exp_w.pos), 32'(got_w.pos));
                    note_field("time_left_out", 32'(exp_w.tleft), 32'(got_w.tleft));
                end
            end
        end
        n_open <= shown_q.size();
        n_fail <= errors;
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the sprite animation sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import sas_pkg::*;

    // Command code the block does not define
    localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;

    localparam int LIMIT       = 400000;
    localparam int PHASE_ITEMS = 380;
    localparam int CALM_ITEMS  = 300;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [CMD_W-1:0]    command;
        logic [TIME_W-1:0]   dt;
        logic [TRIG_W-1:0]   trigger_id;
        logic [STATE_W-1:0]  state_id;
        logic [FRAME_AW-1:0] frame_addr;
        logic [SPR_W-1:0]    sprite_id;
        logic [TIME_W-1:0]   duration;
        logic [POS_W-1:0]    frame_base;
        logic [CNT_W-1:0]    frame_count;
        logic                loop_flag;
        logic [STATE_W-1:0]  next_state;
        logic                entry_valid;
    } cmd_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [SPR_W-1:0]       cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_command;
    logic [TIME_W-1:0]      s_dt;
    logic [TRIG_W-1:0]      s_trigger_id;
    logic [STATE_W-1:0]     s_state_id;
    logic [FRAME_AW-1:0]    s_frame_addr;
    logic [SPR_W-1:0]       s_sprite_id;
    logic [TIME_W-1:0]      s_duration;
    logic [POS_W-1:0]       s_frame_base;
    logic [CNT_W-1:0]       s_frame_count;
    logic                   s_loop_flag;
    logic [STATE_W-1:0]     s_next_state;
    logic                   s_entry_valid;
    logic                   m_valid;
    logic                   m_ready;
    logic [SPR_W-1:0]       m_out_sprite;
    logic                   m_sprite_present;
    logic                   m_state_active;
    logic [STATE_W-1:0]     m_active_state_out;
    logic [POS_W-1:0]       m_frame_pos_out;
    logic signed [TIME_W:0] m_time_left_out;
    int                     n_open;
    int                     n_fail;
    int                     cycles = 0;
    bit                     calm = 1'b0;
    bit                     hold_req = 1'b0;

    always #10 aclk = ~aclk;

    sprite_animation_sequencer i_dut (.*);

    sprite_display_checker i_checker (.*);

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Command word with every field random
    function automatic cmd_word_t noise();
        cmd_word_t w;
        w.command     = CMD_W'($urandom);
        w.dt          = TIME_W'($urandom);
        w.trigger_id  = TRIG_W'($urandom);
        w.state_id    = STATE_W'($urandom);
        w.frame_addr  = FRAME_AW'($urandom);
        w.sprite_id   = SPR_W'($urandom);
        w.duration    = TIME_W'($urandom);
        w.frame_base  = POS_W'($urandom);
        w.frame_count = CNT_W'($urandom);
        w.loop_flag   = 1'($urandom);
        w.next_state  = STATE_W'($urandom);
        w.entry_valid = 1'($urandom);
        return w;
    endfunction

    function automatic cmd_word_t tick_word(input logic [TIME_W-1:0] dt);
        cmd_word_t w;
        w = noise();
        w.command = CMD_TICK;
        w.dt = dt;
        return w;
    endfunction

    function automatic cmd_word_t trigger_word(input logic [TRIG_W-1:0] trig);
        cmd_word_t w;
        w = noise();
        w.command = CMD_TRIGGER;
        w.trigger_id = trig;
        return w;
    endfunction

    function automatic cmd_word_t set_word(input logic [STATE_W-1:0] sid);
        cmd_word_t w;
        w = noise();
        w.command = CMD_SET;
        w.state_id = sid;
        return w;
    endfunction

    function automatic cmd_word_t frame_word(input logic [FRAME_AW-1:0] addr,
                                             input logic [SPR_W-1:0] spr,
                                             input logic [TIME_W-1:0] dur);
        cmd_word_t w;
        w = noise();
        w.command = CMD_WR_FRAME;
        w.frame_addr = addr;
        w.sprite_id = spr;
        w.duration = dur;
        return w;
    endfunction

    function automatic cmd_word_t desc_word(input logic [STATE_W-1:0] sid,
                                            input logic [POS_W-1:0] base,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic loop, input logic ev);
        cmd_word_t w;
        w = noise();
        w.command = CMD_WR_DESC;
        w.state_id = sid;
        w.frame_base = base;
        w.frame_count = cnt;
        w.loop_flag = loop;
        w.entry_valid = ev;
        return w;
    endfunction

    function automatic cmd_word_t xfer_word(input logic [STATE_W-1:0] sid,
                                            input logic [TRIG_W-1:0] trig,
                                            input logic [STATE_W-1:0] nxt, input logic ev);
        cmd_word_t w;
        w = noise();
        w.command = CMD_WR_XFER;
        w.state_id = sid;
        w.trigger_id = trig;
        w.next_state = nxt;
        w.entry_valid = ev;
        return w;
    endfunction

    function automatic cmd_word_t start_word();
        cmd_word_t w;
        w = noise();
        w.command = CMD_START;
        return w;
    endfunction

    // Frame durations mostly short so that ticks often end a frame
    function automatic logic [TIME_W-1:0] pick_dur();
        return ($urandom_range(0, 9) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 20));
    endfunction

    // Triggers cluster on a few ids so they meet written transfers
    function automatic logic [TRIG_W-1:0] pick_trig();
        return ($urandom_range(0, 3) != 0) ? TRIG_W'($urandom_range(0, 3)) : TRIG_W'($urandom);
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t    w;
        int           pick;
        int           r;
        logic [TIME_W-1:0] dt;
        logic [CNT_W-1:0]  cnt;
        pick = $urandom_range(0, 99);
        r = $urandom_range(0, 9);
        if (pick < 40) begin
            dt = (r < 6) ? TIME_W'($urandom_range(0, 12)) :
                 (r < 9) ? TIME_W'($urandom_range(0, 40)) : TIME_W'($urandom);
            w = tick_word(dt);
        end else if (pick < 55) begin
            w = trigger_word(pick_trig());
        end else if (pick < 65) begin
            w = set_word(STATE_W'($urandom));
        end else if (pick < 73) begin
            w = frame_word(FRAME_AW'($urandom), SPR_W'($urandom), pick_dur());
        end else if (pick < 83) begin
            cnt = (r < 7) ? CNT_W'($urandom_range(1, 8)) :
                  (r < 8) ? CNT_W'(0) :
                  (r < 9) ? CNT_W'($urandom_range(256, 511)) : CNT_W'($urandom);
            w = desc_word(STATE_W'($urandom), POS_W'($urandom), cnt, 1'($urandom),
                          $urandom_range(0, 99) < 85);
        end else if (pick < 92) begin
            w = xfer_word(STATE_W'($urandom), pick_trig(), STATE_W'($urandom),
                          $urandom_range(0, 99) < 80);
        end else if (pick < 98) begin
            w = start_word();
        end else begin
            w = noise();
            w.command = CMD_NONE;
        end
        return w;
    endfunction

    // Offer one command word, after an occasional idle burst, until accepted
    task automatic send(input cmd_word_t w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= w.command;
        s_dt          <= w.dt;
        s_trigger_id  <= w.trigger_id;
        s_state_id    <= w.state_id;
        s_frame_addr  <= w.frame_addr;
        s_sprite_id   <= w.sprite_id;
        s_duration    <= w.duration;
        s_frame_base  <= w.frame_base;
        s_frame_count <= w.frame_count;
        s_loop_flag   <= w.loop_flag;
        s_next_state  <= w.next_state;
        s_entry_valid <= w.entry_valid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send(random_word());
    endtask

    // Drain every outstanding result, then write both registers
    task automatic settle_and_configure(input logic [STATE_W-1:0] dflt,
                                        input logic [SPR_W-1:0] spr);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_open != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEFAULT_STATE;
        cfg_wdata <= SPR_W'(dflt);
        @(posedge aclk);
        cfg_index <= CFG_EMPTY_SPRITE;
        cfg_wdata <= spr;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Stimulus
    initial begin
        cmd_word_t    w;
        logic [SPR_W-1:0]  spr;
        logic [TIME_W-1:0] dur;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_DEFAULT_STATE;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_command     = CMD_TICK;
        s_dt          = '0;
        s_trigger_id  = '0;
        s_state_id    = '0;
        s_frame_addr  = '0;
        s_sprite_id   = '0;
        s_duration    = '0;
        s_frame_base  = '0;
        s_frame_count = '0;
        s_loop_flag   = 1'b0;
        s_next_state  = '0;
        s_entry_valid = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        settle_and_configure(STATE_W'(0), SPR_W'(0));

        // Fill the whole frame table so no read ever hits an unwritten entry
        for (int a = 0; a < FRAME_DEPTH; a++) begin
            spr = (a == 0) ? '0 : (a == FRAME_DEPTH - 1) ? '1 : SPR_W'($urandom);
            dur = (a == 1) ? '0 : (a == 2) ? '1 : pick_dur();
            send(frame_word(FRAME_AW'(a), spr, dur));
        end

        // Directed: nothing selected yet
        send(tick_word('1));
        send(trigger_word(TRIG_W'(0)));
        send(start_word());                          // default state still invalid
        send(set_word(STATE_W'(5)));                 // set to invalid state
        w = noise();
        w.command = CMD_NONE;
        w.dt = '1; w.trigger_id = '1; w.state_id = '1; w.frame_addr = '1;
        w.sprite_id = '1; w.duration = '1; w.frame_base = '1; w.frame_count = '1;
        w.loop_flag = 1'b1; w.next_state = '1; w.entry_valid = 1'b1;
        send(w);

        // Descriptors: wrap past the table end, oversized count, no frames, invalid
        send(desc_word(STATE_W'(0), POS_W'(255), CNT_W'(2), 1'b1, 1'b1));
        send(desc_word(STATE_W'(15), POS_W'(0), '1, 1'b0, 1'b1));
        send(desc_word(STATE_W'(3), POS_W'(16), CNT_W'(0), 1'b1, 1'b1));
        send(desc_word(STATE_W'(4), POS_W'(32), CNT_W'(3), 1'b1, 1'b0));
        send(start_word());
        send(tick_word('0));
        send(tick_word('1));

        // Transfers: valid, to an invalid state, to itself, missing
        send(xfer_word(STATE_W'(0), TRIG_W'(15), STATE_W'(15), 1'b1));
        send(xfer_word(STATE_W'(0), TRIG_W'(0), STATE_W'(4), 1'b1));
        send(xfer_word(STATE_W'(15), TRIG_W'(15), STATE_W'(15), 1'b1));
        send(trigger_word(TRIG_W'(0)));
        send(trigger_word(TRIG_W'(1)));
        send(trigger_word(TRIG_W'(15)));
        send(tick_word('0));
        send(trigger_word(TRIG_W'(15)));

        // Set state: same, no frames, invalid
        send(set_word(STATE_W'(15)));
        send(set_word(STATE_W'(3)));
        send(tick_word(TIME_W'(5)));
        send(set_word(STATE_W'(4)));

        // Position left past a shrunk frame count
        send(set_word(STATE_W'(0)));
        send(tick_word('1));
        send(desc_word(STATE_W'(0), POS_W'(255), CNT_W'(1), 1'b0, 1'b1));
        send(tick_word(TIME_W'(1)));

        // Random phases over several register settings
        run_random(PHASE_ITEMS);
        settle_and_configure(STATE_W'(15), '1);
        run_random(PHASE_ITEMS);
        settle_and_configure(STATE_W'(7), SPR_W'(16'h5A5A));
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);
        settle_and_configure(STATE_W'($urandom), SPR_W'($urandom));
        run_random(PHASE_ITEMS - CALM_ITEMS);
        calm = 1'b1;
        run_random(CALM_ITEMS);

        // Drain and give the verdict
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_open != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
